/* rtl/ltrk_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltrk_pkg
// Shared types, constants and the half-step coil table for the light tracker.
// ----------------------------------------------------------------------------
package ltrk_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int THRESH_W        = 10;
    localparam int DWELL_W         = 16;
    localparam int COIL_W          = 4;
    localparam int PHASE_W         = 2;
    localparam int STEP_W          = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_INDEX_W     = 1;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd10;
    localparam logic [DWELL_W-1:0]  DWELL_RESET  = 16'd3;
    localparam logic [STEP_W-1:0]   LAST_STEP    = 3'd7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD = 1'b0,
        CFG_DWELL     = 1'b1
    } cfg_index_t;

    typedef enum logic [PHASE_W-1:0] {
        MODE_IDLE = 2'd0,
        MODE_TILT = 2'd1,
        MODE_PAN  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [COIL_W-1:0]  tilt_coils;
        logic [COIL_W-1:0]  pan_coils;
        logic [PHASE_W-1:0] phase_now;
    } result_t;

    // fwd: 1,3,2,6,4,C,8,9   reverse: 8,C,4,6,2,3,1,9
    function automatic logic [COIL_W-1:0] seq_pattern(input logic [STEP_W-1:0] idx,
                                                      input logic fwd);
        logic [COIL_W-1:0] pat;
        unique case (idx)
            3'd0:    pat = fwd ? 4'h1 : 4'h8;
            3'd1:    pat = fwd ? 4'h3 : 4'hC;
            3'd2:    pat = fwd ? 4'h2 : 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = fwd ? 4'h4 : 4'h2;
            3'd5:    pat = fwd ? 4'hC : 4'h3;
            3'd6:    pat = fwd ? 4'h8 : 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

/* rtl/ltrk_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltrk_in_if / ltrk_out_if
// Valid/ready channels carrying sensor samples in and coil results out.
// ----------------------------------------------------------------------------
interface ltrk_in_if #(
    parameter int SAMPLE_BITS = ltrk_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_up;
    logic [SAMPLE_BITS-1:0] sample_down;
    logic [SAMPLE_BITS-1:0] sample_right;
    logic [SAMPLE_BITS-1:0] sample_left;

    modport source (output valid, sample_up, sample_down, sample_right, sample_left,
                    input ready);
    modport sink   (input valid, sample_up, sample_down, sample_right, sample_left,
                    output ready);
endinterface

interface ltrk_out_if;
    logic                           valid;
    logic                           ready;
    logic [ltrk_pkg::COIL_W-1:0]    tilt_coils;
    logic [ltrk_pkg::COIL_W-1:0]    pan_coils;
    logic [ltrk_pkg::PHASE_W-1:0]   phase_now;

    modport source (output valid, tilt_coils, pan_coils, phase_now, input ready);
    modport sink   (input valid, tilt_coils, pan_coils, phase_now, output ready);
endinterface

/* rtl/ltrk_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltrk_core
// Config registers, tracker state and the per-tick next-state logic.
// ----------------------------------------------------------------------------
module ltrk_core #(
    parameter int SAMPLE_BITS = ltrk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ltrk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ltrk_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              step_en,
    input  logic [SAMPLE_BITS-1:0]            up,
    input  logic [SAMPLE_BITS-1:0]            down,
    input  logic [SAMPLE_BITS-1:0]            right,
    input  logic [SAMPLE_BITS-1:0]            left,
    output ltrk_pkg::result_t                 result_next
);
    import ltrk_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    logic [THRESH_W-1:0]    threshold_reg;
    logic [DWELL_W-1:0]     dwell_ticks_reg;

    mode_t                  mode_reg, mode_next;
    logic                   tilt_down_reg, tilt_down_next;
    logic                   pan_left_reg, pan_left_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [DWELL_W-1:0]     dwell_reg, dwell_next;
    logic [SAMPLE_BITS-1:0] first_reg, first_next;
    logic [SAMPLE_BITS-1:0] second_reg, second_next;
    logic [COIL_W-1:0]      tilt_pat_reg, tilt_pat_next;
    logic [COIL_W-1:0]      pan_pat_reg, pan_pat_next;

    logic [SAMPLE_BITS-1:0] dx, dy;
    logic                   big_move;
    logic                   keep_going;
    logic                   start_pass;
    logic                   drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESH_RESET;
            dwell_ticks_reg <= DWELL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: threshold_reg   <= cfg_data[THRESH_W-1:0];
                CFG_DWELL:     dwell_ticks_reg <= cfg_data[DWELL_W-1:0];
                default:       threshold_reg   <= threshold_reg;
            endcase
        end
    end

    assign dx = (up > down) ? (up - down) : (down - up);
    assign dy = (right > left) ? (right - left) : (left - right);
    assign big_move = (CMP_W'(dx) > CMP_W'(threshold_reg))
                   && (CMP_W'(dy) > CMP_W'(threshold_reg));

    // direction test on the pair stored when the ending pass began
    always_comb
    begin
        if ((mode_reg == MODE_TILT) ? tilt_down_reg : pan_left_reg)
            keep_going = first_reg > second_reg;
        else
            keep_going = second_reg > first_reg;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        tilt_down_next = tilt_down_reg;
        pan_left_next  = pan_left_reg;
        step_next      = step_reg;
        dwell_next     = dwell_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        tilt_pat_next  = tilt_pat_reg;
        pan_pat_next   = pan_pat_reg;
        start_pass     = 1'b0;
        drive          = 1'b0;

        unique case (mode_reg)
            MODE_TILT, MODE_PAN:
            begin
                priority if (dwell_reg < dwell_ticks_reg)
                    dwell_next = DWELL_W'(dwell_reg + 1'b1);
                else if (step_reg != LAST_STEP)
                begin
                    step_next  = STEP_W'(step_reg + 1'b1);
                    dwell_next = DWELL_W'(1);
                    drive      = 1'b1;
                end
                else if (keep_going)
                    start_pass = 1'b1;
                else if (mode_reg == MODE_TILT)
                begin
                    mode_next  = MODE_PAN;
                    start_pass = 1'b1;
                end
                else
                begin
                    mode_next  = MODE_IDLE;
                    step_next  = '0;
                    dwell_next = '0;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (big_move)
                begin
                    tilt_down_next = up > down;
                    pan_left_next  = right > left;
                    mode_next      = MODE_TILT;
                    start_pass     = 1'b1;
                end
            end
        endcase

        if (start_pass)
        begin
            step_next  = '0;
            dwell_next = DWELL_W'(1);
            drive      = 1'b1;
            if (mode_next == MODE_TILT)
            begin
                first_next  = up;
                second_next = down;
            end
            else
            begin
                first_next  = right;
                second_next = left;
            end
        end

        if (drive)
        begin
            if (mode_next == MODE_TILT)
                tilt_pat_next = seq_pattern(step_next, !tilt_down_next);
            else if (mode_next == MODE_PAN)
                pan_pat_next = seq_pattern(step_next, pan_left_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            tilt_down_reg <= 1'b0;
            pan_left_reg  <= 1'b0;
            step_reg      <= '0;
            dwell_reg     <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            tilt_pat_reg  <= '0;
            pan_pat_reg   <= '0;
        end
        else if (step_en)
        begin
            mode_reg      <= mode_next;
            tilt_down_reg <= tilt_down_next;
            pan_left_reg  <= pan_left_next;
            step_reg      <= step_next;
            dwell_reg     <= dwell_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            tilt_pat_reg  <= tilt_pat_next;
            pan_pat_reg   <= pan_pat_next;
        end
    end

    assign result_next.tilt_coils = tilt_pat_next;
    assign result_next.pan_coils  = pan_pat_next;
    assign result_next.phase_now  = mode_next;

endmodule

/* rtl/ltrk_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltrk_out_stage
// Result register with valid flag; takes a new result whenever it is empty
// or its current one leaves this cycle.
// ----------------------------------------------------------------------------
module ltrk_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ltrk_pkg::result_t result_in,
    ltrk_out_if.source        out_ch
);
    import ltrk_pkg::*;

    logic    valid_reg;
    result_t result_reg;
    logic    load;

    assign in_ready = !valid_reg || out_ch.ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.tilt_coils = result_reg.tilt_coils;
    assign out_ch.pan_coils  = result_reg.pan_coils;
    assign out_ch.phase_now  = result_reg.phase_now;

endmodule

/* rtl/two_axis_light_tracker_stepper_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_axis_light_tracker_stepper_unit
// Two-axis light tracker driving tilt and pan steppers with half-step patterns.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per timer tick with the up, down, right and left
//            light samples. Accepted when valid and ready are both high.
//   out_ch : one result per request: tilt coil pattern, pan coil pattern and
//            the phase after that tick (idle, tilt, pan).
//   cfg    : cfg_we/cfg_index/cfg_data write the imbalance threshold (0) and
//            the dwell in ticks (1); write only while idle.
// The result is registered at the edge that accepts the request.
// Throughput is one request per cycle while the result register is empty
// or being taken, set by the single next-state pass between the tracker
// state and the result register. When the receiver stalls, the held result
// stays put and ready drops only while the result register is full and not
// being taken. Reset clears the tracker to idle with both patterns zero,
// threshold 10 and dwell 3.
// ----------------------------------------------------------------------------
module two_axis_light_tracker_stepper_unit #(
    parameter int SAMPLE_BITS = ltrk_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ltrk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ltrk_pkg::CFG_DATA_W-1:0]   cfg_data,
    ltrk_in_if.sink                           in_ch,
    ltrk_out_if.source                        out_ch
);
    import ltrk_pkg::*;

    result_t result_next;
    logic    take;

    assign take = in_ch.valid && in_ch.ready;

    ltrk_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step_en     (take),
        .up          (in_ch.sample_up),
        .down        (in_ch.sample_down),
        .right       (in_ch.sample_right),
        .left        (in_ch.sample_left),
        .result_next (result_next)
    );

    ltrk_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .result_in (result_next),
        .out_ch    (out_ch)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-axis light tracker. A short table of sensor
// ticks and register writes comes first, then random phases with a drifting light
// direction. Every result is compared with a tick-accurate tracker model kept in
// the bench, or the table on typed rows; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import ltrk_pkg::*;

    localparam int SB             = SAMPLE_BITS_DEF;
    localparam int SMAX           = (1 << SB) - 1;
    localparam int CLK_PERIOD     = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int N_PHASES       = 11;
    localparam int PHASE_TICKS    = 150;

    typedef logic [SB-1:0] sample_t;

    typedef struct packed {
        sample_t up;
        sample_t down;
        sample_t right;
        sample_t left;
    } tick_t;

    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_SET_THRESHOLD,
        ROW_SET_DWELL
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        tick_t                  tick;
        logic [CFG_DATA_W-1:0]  value;
        logic                   typed;
        result_t                want;
    } row_t;

    typedef enum int {
        SHAPE_WIDE,
        SHAPE_EVEN,
        SHAPE_EDGE,
        SHAPE_RAIL,
        SHAPE_ANY
    } pair_shape_t;

    // half-step sequences: ascending 1,3,2,6,4,C,8,9 and descending 8,C,4,6,2,3,1,9
    localparam logic [COIL_W-1:0] HALF_ASC [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [COIL_W-1:0] HALF_DESC [8] =
        '{4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9};

    // reset defaults: threshold 10, dwell 3
    localparam int N_ROWS = 20;
    localparam row_t DIRECTED [N_ROWS] = '{
        '{ROW_TICK, '{10'd0, 10'd0, 10'd0, 10'd0}, 16'd0, 1'b1,
          '{4'h0, 4'h0, MODE_IDLE}},
        // both differences sit exactly on the threshold
        '{ROW_TICK, '{10'd20, 10'd10, 10'd10, 10'd20}, 16'd0, 1'b1,
          '{4'h0, 4'h0, MODE_IDLE}},
        '{ROW_TICK, '{10'd21, 10'd10, 10'd10, 10'd21}, 16'd0, 1'b1,
          '{4'h8, 4'h0, MODE_TILT}},
        '{ROW_TICK, '{10'd0, 10'd0, 10'd0, 10'd0}, 16'd0, 1'b1,
          '{4'h8, 4'h0, MODE_TILT}},
        '{ROW_TICK, '{10'd0, 10'd0, 10'd0, 10'd0}, 16'd0, 1'b1,
          '{4'h8, 4'h0, MODE_TILT}},
        '{ROW_TICK, '{10'd0, 10'd0, 10'd0, 10'd0}, 16'd0, 1'b1,
          '{4'hC, 4'h0, MODE_TILT}},
        '{ROW_SET_DWELL, '0, 16'd0, 1'b0, '0},
        '{ROW_SET_THRESHOLD, '0, 16'd0, 1'b0, '0},
        '{ROW_TICK, '{10'd1, 10'd0, 10'd0, 10'd1}, 16'd0, 1'b0, '0},
        '{ROW_TICK, '{10'd0, 10'd1023, 10'd1023, 10'd0}, 16'd0, 1'b0, '0},
        '{ROW_SET_DWELL, '0, 16'd1, 1'b0, '0},
        '{ROW_TICK, '{10'd0, 10'd1023, 10'd1023, 10'd0}, 16'd0, 1'b0, '0},
        '{ROW_TICK, '{10'd1023, 10'd0, 10'd0, 10'd1023}, 16'd0, 1'b0, '0},
        '{ROW_TICK, '{10'd1023, 10'd1023, 10'd0, 10'd0}, 16'd0, 1'b0, '0},
        '{ROW_SET_THRESHOLD, '0, 16'd1023, 1'b0, '0},
        '{ROW_TICK, '{10'd1023, 10'd0, 10'd1023, 10'd0}, 16'd0, 1'b0, '0},
        '{ROW_TICK, '{10'd0, 10'd1023, 10'd0, 10'd1023}, 16'd0, 1'b0, '0},
        '{ROW_SET_DWELL, '0, 16'd65535, 1'b0, '0},
        '{ROW_TICK, '{10'd1023, 10'd0, 10'd0, 10'd1023}, 16'd0, 1'b0, '0},
        '{ROW_TICK, '{10'd512, 10'd511, 10'd511, 10'd512}, 16'd0, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ltrk_in_if #(.SAMPLE_BITS(SB)) in_ch ();
    ltrk_out_if                    out_ch ();

    two_axis_light_tracker_stepper_unit #(.SAMPLE_BITS(SB)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // tracker model state and its copy of the registers
    mode_t                trk_mode;
    logic                 tilt_down;
    logic                 pan_left;
    logic [STEP_W-1:0]    step;
    logic [DWELL_W-1:0]   dwell_cnt;
    sample_t              pass_a;
    sample_t              pass_b;
    logic [COIL_W-1:0]    tilt_pat;
    logic [COIL_W-1:0]    pan_pat;
    logic [THRESH_W-1:0]  thr_cfg;
    logic [DWELL_W-1:0]   dwell_cfg;

    result_t coils_q [$];
    int      errors = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;
    logic    next_typed;
    result_t next_want;
    logic    lean_down;
    logic    lean_left;
    logic [9:0] stall_tick = '0;

    task automatic show_pattern();
        if (trk_mode == MODE_TILT)
            tilt_pat = tilt_down ? HALF_DESC[step] : HALF_ASC[step];
        else if (trk_mode == MODE_PAN)
            pan_pat = pan_left ? HALF_ASC[step] : HALF_DESC[step];
    endtask

    task automatic open_pass(input sample_t a, input sample_t b);
        pass_a    = a;
        pass_b    = b;
        step      = '0;
        dwell_cnt = 1;
        show_pattern();
    endtask

    // the pair stored at the start of the finished pass still favors the move
    function automatic logic pass_favored();
        if (trk_mode == MODE_TILT)
            return tilt_down ? (pass_a > pass_b) : (pass_b > pass_a);
        return pan_left ? (pass_a > pass_b) : (pass_b > pass_a);
    endfunction

    task automatic advance_tracker(input tick_t t, output result_t r);
        sample_t dx;
        sample_t dy;
        if (trk_mode != MODE_TILT && trk_mode != MODE_PAN) begin
            dx = (t.up > t.down) ? t.up - t.down : t.down - t.up;
            dy = (t.right > t.left) ? t.right - t.left : t.left - t.right;
            trk_mode = MODE_IDLE;
            if (dx > thr_cfg && dy > thr_cfg) begin
                tilt_down = t.up > t.down;
                pan_left  = t.right > t.left;
                trk_mode  = MODE_TILT;
                open_pass(t.up, t.down);
            end
        end
        else if (dwell_cnt < dwell_cfg) begin
            dwell_cnt = dwell_cnt + 1'b1;
        end
        else if (step < LAST_STEP) begin
            step      = step + 1'b1;
            dwell_cnt = 1;
            show_pattern();
        end
        else if (pass_favored()) begin
            if (trk_mode == MODE_TILT)
                open_pass(t.up, t.down);
            else
                open_pass(t.right, t.left);
        end
        else if (trk_mode == MODE_TILT) begin
            trk_mode = MODE_PAN;
            open_pass(t.right, t.left);
        end
        else begin
            trk_mode  = MODE_IDLE;
            step      = '0;
            dwell_cnt = '0;
        end
        r.tilt_coils = tilt_pat;
        r.pan_coils  = pan_pat;
        r.phase_now  = trk_mode;
    endtask

    // returns {a, b}; lean asks for a > b most of the time
    function automatic logic [2*SB-1:0] make_pair(input pair_shape_t shape, input logic lean);
        int      d;
        int      lo;
        sample_t a;
        sample_t b;
        sample_t tmp;
        case (shape)
            SHAPE_WIDE, SHAPE_EDGE: begin
                if (shape == SHAPE_EDGE)
                    d = int'(thr_cfg) + int'($urandom_range(0, 1));
                else if (int'(thr_cfg) >= SMAX)
                    d = SMAX;
                else
                    d = $urandom_range(SMAX, int'(thr_cfg) + 1);
                if (d > SMAX)
                    d = SMAX;
                lo = $urandom_range(0, SMAX - d);
                a  = sample_t'(lo + d);
                b  = sample_t'(lo);
                if ((($urandom_range(0, 3) != 0) ? lean : !lean) == 1'b0) begin
                    tmp = a;
                    a   = b;
                    b   = tmp;
                end
            end
            SHAPE_EVEN: begin
                a = sample_t'($urandom);
                b = a;
            end
            SHAPE_RAIL: begin
                a = $urandom_range(0, 1) ? '1 : '0;
                b = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                a = sample_t'($urandom);
                b = sample_t'($urandom);
            end
        endcase
        return {a, b};
    endfunction

    function automatic tick_t random_tick();
        int          pick;
        pair_shape_t tilt_shape;
        pair_shape_t pan_shape;
        tick_t       t;
        pick = $urandom_range(0, 19);
        tilt_shape = SHAPE_WIDE;
        pan_shape  = SHAPE_WIDE;
        case (pick)
            13:      tilt_shape = SHAPE_EVEN;
            14:      begin tilt_shape = SHAPE_EDGE; pan_shape = SHAPE_EDGE; end
            15:      begin tilt_shape = SHAPE_RAIL; pan_shape = SHAPE_RAIL; end
            16, 17:  begin tilt_shape = SHAPE_ANY; pan_shape = SHAPE_ANY; end
            18:      pan_shape = SHAPE_EVEN;
            19:      pan_shape = SHAPE_EDGE;
            default: ;
        endcase
        {t.up, t.down}    = make_pair(tilt_shape, lean_down);
        {t.right, t.left} = make_pair(pan_shape, lean_left);
        return t;
    endfunction

    task automatic send_tick(input tick_t t, input logic typed, input result_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        next_typed = typed;
        next_want  = want;
        in_ch.valid        <= 1'b1;
        in_ch.sample_up    <= t.up;
        in_ch.sample_down  <= t.down;
        in_ch.sample_right <= t.right;
        in_ch.sample_left  <= t.left;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (coils_q.size() != 0)
            @(negedge clk);
    endtask

    // balanced samples never start or extend a move, so the tracker runs down
    task automatic settle();
        sample_t v;
        sample_t w;
        wait_results();
        while (trk_mode != MODE_IDLE) begin
            v = sample_t'($urandom);
            w = sample_t'($urandom);
            send_tick('{v, v, w, w}, 1'b0, '0);
            wait_results();
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            thr_cfg = value[THRESH_W-1:0];
        else
            dwell_cfg = value[DWELL_W-1:0];
    endtask

    // receiver ready, cycling through always-ready, random and sparse patterns
    always @(negedge clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[9:8])
            2'd0:    out_ch.ready <= 1'b1;
            2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
            2'd2:    out_ch.ready <= (stall_tick % 3 == 0);
            default: out_ch.ready <= $urandom_range(0, 1);
        endcase
    end

    always @(posedge clk) begin : scoreboard
        result_t pred;
        result_t want;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                advance_tracker('{in_ch.sample_up, in_ch.sample_down,
                                  in_ch.sample_right, in_ch.sample_left}, pred);
                coils_q.push_back(next_typed ? next_want : pred);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (coils_q.size() == 0) begin
                    $error("result with no request pending");
                    errors++;
                end
                else begin
                    want = coils_q.pop_front();
                    if (out_ch.tilt_coils !== want.tilt_coils) begin
                        $error("tilt_coils: expected %h, got %h",
                               want.tilt_coils, out_ch.tilt_coils);
                        errors++;
                    end
                    if (out_ch.pan_coils !== want.pan_coils) begin
                        $error("pan_coils: expected %h, got %h",
                               want.pan_coils, out_ch.pan_coils);
                        errors++;
                    end
                    if (out_ch.phase_now !== want.phase_now) begin
                        $error("phase_now: expected %0d, got %0d",
                               want.phase_now, out_ch.phase_now);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [THRESH_W-1:0] thr;
        logic [DWELL_W-1:0]  dwell;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.sample_up    = '0;
        in_ch.sample_down  = '0;
        in_ch.sample_right = '0;
        in_ch.sample_left  = '0;
        out_ch.ready       = 1'b0;
        next_typed         = 1'b0;
        next_want          = '0;
        lean_down          = 1'b0;
        lean_left          = 1'b0;
        trk_mode           = MODE_IDLE;
        tilt_down          = 1'b0;
        pan_left           = 1'b0;
        step               = '0;
        dwell_cnt          = '0;
        pass_a             = '0;
        pass_b             = '0;
        tilt_pat           = '0;
        pan_pat            = '0;
        thr_cfg            = THRESH_RESET;
        dwell_cfg          = DWELL_RESET;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            case (DIRECTED[i].kind)
                ROW_TICK:
                    send_tick(DIRECTED[i].tick, DIRECTED[i].typed, DIRECTED[i].want);
                ROW_SET_THRESHOLD: begin
                    settle();
                    write_reg(CFG_THRESHOLD, DIRECTED[i].value);
                end
                default: begin
                    settle();
                    write_reg(CFG_DWELL, DIRECTED[i].value);
                end
            endcase
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       begin thr = THRESH_RESET; dwell = DWELL_RESET; end
                1:       begin thr = '0;           dwell = '0;          end
                2:       begin thr = '1;           dwell = '1;          end
                3:       begin thr = '0;           dwell = 16'd1;       end
                4:       begin thr = 10'd1000;     dwell = 16'd2;       end
                default: begin
                    thr   = ($urandom_range(0, 4) == 0) ? THRESH_W'($urandom)
                                                        : THRESH_W'($urandom_range(0, 60));
                    dwell = DWELL_W'($urandom_range(0, 5));
                end
            endcase
            settle();
            write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
            write_reg(CFG_DWELL, CFG_DATA_W'(dwell));
            lean_down = $urandom_range(0, 1);
            lean_left = $urandom_range(0, 1);
            repeat (PHASE_TICKS)
            begin
                // light source drifts now and then
                if ($urandom_range(0, 39) == 0)
                    lean_down = !lean_down;
                if ($urandom_range(0, 39) == 0)
                    lean_left = !lean_left;
                send_tick(random_tick(), 1'b0, '0);
            end
        end

        wait_results();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
